[hw/rtl/blr_pkg.sv]
// Shared types and constants for the Bresenham line rasterizer.
package blr_pkg;

    localparam int CoordBits   = 13;
    localparam int CfgBits     = 13;
    localparam int FillBits    = 8;
    localparam int ErrBits     = CoordBits + 3;
    localparam int CfgIdxBits  = 1;
    localparam int DefMaxSpan  = 64;
    localparam int DefCmdDepth = 2;
    localparam int CmpBits     = (CoordBits - 1 > CfgBits) ? CoordBits - 1 : CfgBits;

    localparam logic [CfgBits-1:0] ImageSizeReset = CfgBits'(4096);

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic signed [ErrBits-1:0]   t_err;

    // One classified line command, ready for the walker
    typedef struct packed {
        t_coord              major;
        t_coord              minor;
        t_err                err;
        t_err                dec;
        t_err                adj;
        logic                neg;
        logic                steep;
        logic [FillBits-1:0] fill;
        logic                zero;
        logic                trunc;
    } t_cmd;

    typedef struct packed {
        logic [CfgBits-1:0] width;
        logic [CfgBits-1:0] height;
    } t_img_size;

    typedef enum logic {
        WALK_IDLE,
        WALK_RUN
    } t_walk_state;

endpackage

[hw/rtl/blr_front.sv]
// Front end: accepts line commands, swaps steep axes and orders end points.
module blr_front #(
    parameter int MAX_SPAN = 64,
    parameter int CNT_BITS = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic signed [blr_pkg::CoordBits-1:0] i_start_x,
    input  logic signed [blr_pkg::CoordBits-1:0] i_start_y,
    input  logic signed [blr_pkg::CoordBits-1:0] i_end_x,
    input  logic signed [blr_pkg::CoordBits-1:0] i_end_y,
    input  logic        [blr_pkg::FillBits-1:0]  i_fill_value,
    output logic                                 o_wr,
    input  logic                                 i_fifo_full,
    output blr_pkg::t_cmd                        o_cmd,
    output logic        [CNT_BITS-1:0]           o_cnt
);
    import blr_pkg::*;

    localparam logic [CNT_BITS-1:0]  CntTop  = CNT_BITS'(MAX_SPAN - 1);
    localparam logic [CoordBits:0]   SpanMax = (CoordBits + 1)'(MAX_SPAN);

    logic signed [CoordBits:0] w_dx;
    logic signed [CoordBits:0] w_dy;
    logic        [CoordBits:0] w_adx;
    logic        [CoordBits:0] w_ady;
    logic                      w_steep;
    logic                      w_take;

    logic                      r_s1_valid;
    t_coord                    r_ax;
    t_coord                    r_ay;
    t_coord                    r_bx;
    t_coord                    r_by;
    logic        [CoordBits:0] r_dmaj;
    logic        [CoordBits:0] r_dmin;
    logic                      r_steep;
    logic [FillBits-1:0]       r_fill;

    logic                      w_order;
    t_coord                    w_min_s;
    t_coord                    w_min_e;
    logic        [CoordBits:0] w_span_m1;
    logic        [CoordBits:0] w_ddiff;
    logic                      w_trunc;

    // Absolute deltas and steepness
    assign w_dx    = (CoordBits + 1)'(i_end_x) - (CoordBits + 1)'(i_start_x);
    assign w_dy    = (CoordBits + 1)'(i_end_y) - (CoordBits + 1)'(i_start_y);
    assign w_adx   = w_dx[CoordBits] ? -w_dx : w_dx;
    assign w_ady   = w_dy[CoordBits] ? -w_dy : w_dy;
    assign w_steep = w_ady > w_adx;

    // Stage one takes a beat when empty or when it drains this cycle
    assign o_full = r_s1_valid && i_fifo_full;
    assign o_wr   = r_s1_valid && !i_fifo_full;
    assign w_take = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_take) begin
            r_s1_valid <= 1'b1;
        end else if (o_wr) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Hold the axis-swapped end points
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ax    <= w_steep ? i_start_y : i_start_x;
            r_ay    <= w_steep ? i_start_x : i_start_y;
            r_bx    <= w_steep ? i_end_y : i_end_x;
            r_by    <= w_steep ? i_end_x : i_end_y;
            r_dmaj  <= w_steep ? w_ady : w_adx;
            r_dmin  <= w_steep ? w_adx : w_ady;
            r_steep <= w_steep;
            r_fill  <= i_fill_value;
        end
    end

    // Order along the major axis and precompute the error steps
    assign w_order   = r_ax > r_bx;
    assign w_min_s   = w_order ? r_by : r_ay;
    assign w_min_e   = w_order ? r_ay : r_by;
    assign w_span_m1 = r_dmaj - 1'b1;
    assign w_ddiff   = r_dmaj - r_dmin;
    assign w_trunc   = r_dmaj > SpanMax;

    always_comb begin
        o_cmd.major = w_order ? r_bx : r_ax;
        o_cmd.minor = w_min_s;
        o_cmd.err   = ErrBits'(r_dmaj);
        o_cmd.dec   = ErrBits'({r_dmin, 1'b0});
        o_cmd.adj   = ErrBits'({w_ddiff, 1'b0});
        o_cmd.neg   = !(w_min_s < w_min_e);
        o_cmd.steep = r_steep;
        o_cmd.fill  = r_fill;
        o_cmd.zero  = (r_dmaj == '0);
        o_cmd.trunc = w_trunc;
        o_cnt       = w_trunc ? CntTop : w_span_m1[CNT_BITS-1:0];
    end

endmodule

[hw/rtl/blr_cmd_fifo.sv]
// Short command queue between the front end and the walker.
module blr_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [AddrBits:0] r_wr_ptr;
    logic [AddrBits:0] r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AddrBits-1:0] == r_rd_ptr[AddrBits-1:0])
                  && (r_wr_ptr[AddrBits] != r_rd_ptr[AddrBits]);
    assign o_data  = r_mem[r_rd_ptr[AddrBits-1:0]];

    // Advance pointers on each beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Store the written entry
    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wr_ptr[AddrBits-1:0]] <= i_data;
        end
    end

endmodule

[hw/rtl/blr_walker.sv]
// Back end: walks major axis one pixel per cycle into a free output register.
module blr_walker #(
    parameter int CNT_BITS = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_fifo_empty,
    output logic                                 o_fifo_rd,
    input  blr_pkg::t_cmd                        i_cmd,
    input  logic        [CNT_BITS-1:0]           i_cnt,
    input  blr_pkg::t_img_size                   i_size,
    input  logic                                 i_pop,
    output logic                                 o_empty,
    output logic signed [blr_pkg::CoordBits-1:0] o_pixel_x,
    output logic signed [blr_pkg::CoordBits-1:0] o_pixel_y,
    output logic        [blr_pkg::FillBits-1:0]  o_pixel_value,
    output logic                                 o_write_enable,
    output logic                                 o_last,
    output logic                                 o_truncated
);
    import blr_pkg::*;

    t_walk_state           r_state;
    t_walk_state           n_state;
    t_coord                r_major;
    t_coord                r_minor;
    t_err                  r_err;
    t_err                  r_dec;
    t_err                  r_adj;
    logic                  r_neg;
    logic                  r_steep;
    logic [FillBits-1:0]   r_fill;
    logic                  r_zero;
    logic                  r_trunc;
    logic [CNT_BITS-1:0]   r_rem;

    logic                  r_o_valid;
    t_coord                r_px;
    t_coord                r_py;
    logic [FillBits-1:0]   r_val;
    logic                  r_we;
    logic                  r_last;
    logic                  r_otr;

    logic                  w_slot;
    logic                  w_emit;
    logic                  w_is_last;
    logic                  w_load;
    t_coord                w_px;
    t_coord                w_py;
    logic                  w_in_img;
    t_err                  w_e1;

    // Output slot is free when empty or drained this cycle
    assign w_slot    = !r_o_valid || i_pop;
    assign w_is_last = r_zero || (r_rem == '0);
    assign w_px      = r_steep ? r_minor : r_major;
    assign w_py      = r_steep ? r_major : r_minor;
    assign w_in_img  = !w_px[CoordBits-1] && !w_py[CoordBits-1]
                    && (CmpBits'(w_px[CoordBits-2:0]) < CmpBits'(i_size.width))
                    && (CmpBits'(w_py[CoordBits-2:0]) < CmpBits'(i_size.height));
    assign w_e1      = r_err - r_dec;

    // Sequence commands: load, emit, reload on the last beat
    always_comb begin
        n_state = r_state;
        w_emit  = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            WALK_IDLE: begin
                if (!i_fifo_empty) begin
                    w_load  = 1'b1;
                    n_state = WALK_RUN;
                end
            end
            WALK_RUN: begin
                w_emit = w_slot;
                if (w_slot && w_is_last) begin
                    w_load  = !i_fifo_empty;
                    n_state = i_fifo_empty ? WALK_IDLE : WALK_RUN;
                end
            end
            default: begin
                n_state = WALK_IDLE;
            end
        endcase
    end

    assign o_fifo_rd = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WALK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load a new command or take one Bresenham step
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_major <= i_cmd.major;
            r_minor <= i_cmd.minor;
            r_err   <= i_cmd.err;
            r_dec   <= i_cmd.dec;
            r_adj   <= i_cmd.adj;
            r_neg   <= i_cmd.neg;
            r_steep <= i_cmd.steep;
            r_fill  <= i_cmd.fill;
            r_zero  <= i_cmd.zero;
            r_trunc <= i_cmd.trunc;
            r_rem   <= i_cnt;
        end else if (w_emit) begin
            r_major <= r_major + 1'b1;
            r_rem   <= r_rem - 1'b1;
            if (w_e1[ErrBits-1]) begin
                r_minor <= r_neg ? r_minor - 1'b1 : r_minor + 1'b1;
                r_err   <= r_err + r_adj;
            end else begin
                r_err   <= w_e1;
            end
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_pop) begin
            r_o_valid <= 1'b0;
        end
    end

    // Capture the result beat; a zero-length line gives an empty result
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_zero) begin
                r_px   <= '0;
                r_py   <= '0;
                r_val  <= '0;
                r_we   <= 1'b0;
                r_last <= 1'b1;
                r_otr  <= 1'b0;
            end else begin
                r_px   <= w_px;
                r_py   <= w_py;
                r_val  <= r_fill;
                r_we   <= w_in_img;
                r_last <= w_is_last;
                r_otr  <= w_is_last && r_trunc;
            end
        end
    end

    assign o_empty        = !r_o_valid;
    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_pixel_value  = r_val;
    assign o_write_enable = r_we;
    assign o_last         = r_last;
    assign o_truncated    = r_otr;

endmodule

[hw/rtl/bresenham_line_rasterizer_top.sv]
// Top level of the Bresenham line rasterizer: config registers, front, queue, walker.
//
// Input channel: one line command (two end points and a fill value) per beat,
// taken at a clock edge with push high and full low. Result channel: one pixel
// per beat, shown while empty is low and taken at an edge with pop high.
// A command of major span N gives min(N, MAX_SPAN) pixels, the final one with
// o_last set and, when the line was cut at MAX_SPAN, o_truncated set. A
// zero-length command gives one empty result with o_last set.
// When idle, a command passes through the front register, the command queue, the
// walker and the output register before its first pixel shows.
// The walker emits one pixel per cycle while pop keeps the output slot free; a
// command already queued follows the last pixel of the one before with no gap.
// While the walker is busy the front and the command queue keep taking up to
// CMD_DEPTH + 1 further commands before full rises.
// When pop stays low the output register holds its beat and the walker stalls.
// Synchronous reset empties all stages and sets image width and height to 4096.
// Write the size registers via i_cfg_we only while idle; not enforced by the block.
module bresenham_line_rasterizer_top #(
    parameter int MAX_SPAN  = blr_pkg::DefMaxSpan,
    parameter int CMD_DEPTH = blr_pkg::DefCmdDepth
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [blr_pkg::CoordBits-1:0]  i_start_x,
    input  logic signed [blr_pkg::CoordBits-1:0]  i_start_y,
    input  logic signed [blr_pkg::CoordBits-1:0]  i_end_x,
    input  logic signed [blr_pkg::CoordBits-1:0]  i_end_y,
    input  logic        [blr_pkg::FillBits-1:0]   i_fill_value,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [blr_pkg::CoordBits-1:0]  o_pixel_x,
    output logic signed [blr_pkg::CoordBits-1:0]  o_pixel_y,
    output logic        [blr_pkg::FillBits-1:0]   o_pixel_value,
    output logic                                  o_write_enable,
    output logic                                  o_last,
    output logic                                  o_truncated,
    input  logic                                  i_cfg_we,
    input  logic        [blr_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic        [blr_pkg::CfgBits-1:0]    i_cfg_data
);
    import blr_pkg::*;

    localparam int CntBits = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int FifoW   = $bits(t_cmd) + CntBits;

    t_img_size           r_size;
    logic                w_wr;
    logic                w_fifo_full;
    logic                w_fifo_empty;
    logic                w_fifo_rd;
    t_cmd                w_front_cmd;
    logic [CntBits-1:0]  w_front_cnt;
    logic [FifoW-1:0]    w_fifo_out;
    t_cmd                w_walk_cmd;
    logic [CntBits-1:0]  w_walk_cnt;

    // Size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size.width  <= ImageSizeReset;
            r_size.height <= ImageSizeReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_size.width  <= i_cfg_data;
                CFG_HEIGHT: r_size.height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    blr_front #(
        .MAX_SPAN (MAX_SPAN),
        .CNT_BITS (CntBits)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_fill_value (i_fill_value),
        .o_wr         (w_wr),
        .i_fifo_full  (w_fifo_full),
        .o_cmd        (w_front_cmd),
        .o_cnt        (w_front_cnt)
    );

    blr_cmd_fifo #(
        .WIDTH (FifoW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_data  ({w_front_cmd, w_front_cnt}),
        .o_full  (w_fifo_full),
        .i_rd    (w_fifo_rd),
        .o_data  (w_fifo_out),
        .o_empty (w_fifo_empty)
    );

    assign w_walk_cmd = w_fifo_out[FifoW-1:CntBits];
    assign w_walk_cnt = w_fifo_out[CntBits-1:0];

    blr_walker #(
        .CNT_BITS (CntBits)
    ) u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fifo_empty   (w_fifo_empty),
        .o_fifo_rd      (w_fifo_rd),
        .i_cmd          (w_walk_cmd),
        .i_cnt          (w_walk_cnt),
        .i_size         (r_size),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_value  (o_pixel_value),
        .o_write_enable (o_write_enable),
        .o_last         (o_last),
        .o_truncated    (o_truncated)
    );

    // A truncated flag only rides on the final beat of a command
    a_trunc_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_truncated |-> o_last)
        else $error("truncated set on a beat that is not last");

    // A written pixel never has a negative coordinate
    a_we_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_write_enable |-> !o_pixel_x[CoordBits-1] && !o_pixel_y[CoordBits-1])
        else $error("write enable on a negative coordinate");

    // Reset drains the result side
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present right after reset");

    // The queue never reads while empty
    a_fifo_rd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_rd |-> !w_fifo_empty)
        else $error("command queue read while empty");

endmodule
